### rtl/wfw_pkg.sv
// Shared constants, widths and types for the wave folder / wrapper.
package wfw_pkg;

  // Voltage format and gain/bias format
  localparam int FRAC_BITS = 12;
  localparam int GB_FRAC   = 12;
  localparam int ACC_SHIFT = 2 * GB_FRAC;

  localparam int ONE_V    = 1 << FRAC_BITS;
  localparam int ONE_GB   = 1 << GB_FRAC;
  localparam int SPAN     = 10 * ONE_V;
  localparam int TWO_SPAN = 2 * SPAN;
  localparam int CTR_UNI  = 5 * ONE_V;
  localparam int MIN_BI   = -5 * ONE_V;
  localparam int EPS_LSB  = ONE_V / 1000000;

  // Port widths
  localparam int SAMPLE_W = 18;
  localparam int GAIN_W   = 16;
  localparam int BIAS_W   = 14;
  localparam int OUT_W    = 17;

  // Datapath widths
  localparam int D_W    = SAMPLE_W + 1;
  localparam int FAC_W  = BIAS_W + 1;
  localparam int GF_W   = GAIN_W + FAC_W;
  localparam int PROD_W = D_W + GF_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int Y_W    = ACC_W - ACC_SHIFT;
  localparam int U_W    = Y_W + 1;
  localparam int MOD_SH = FRAC_BITS + 2;
  localparam int Q_W    = U_W - MOD_SH;
  localparam int X_W    = Q_W + 1;
  localparam int Q_OFF  = 5 * (((1 << (Q_W - 1)) + 4) / 5);
  localparam int NIB_N  = (X_W + 3) / 4;
  localparam int SUM_W  = $clog2(NIB_N * 15 + 1);
  localparam int R_W    = MOD_SH + 3;

  localparam int STAGES = 8;

  // APB register map
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam logic [1:0] REG_WRAP_MODE = 2'd0;
  localparam logic [1:0] REG_UNIPOLAR  = 2'd1;
  localparam logic [1:0] REG_ASYM_GAIN = 2'd2;

  typedef struct packed {
    logic wrap_mode;
    logic unipolar_range;
    logic asymmetric_gain;
  } cfg_t;

endpackage

### rtl/wave_fold_wrap.sv
// Top level of the triangle wave folder / wrapper with its APB register block.
//
// Usage: present sample_in_i, gain_amount_i and bias_amount_i with start high;
// the transfer is taken at that clock edge whenever busy is low. busy stays low,
// so one sample may enter on every cycle. Each result appears on sample_out_o
// for exactly one cycle, marked by done_o, and must be taken in that cycle.
// Throughput is one sample per cycle, set by the eight-stage datapath
// (factor, gain multiply, offset multiply, accumulate, range check,
// digit sum, remainder, fold/wrap select).
// Configuration: APB registers at byte 0 (wrap_mode), 4 (unipolar_range),
// 8 (asymmetric_gain), bit 0 each. Write them only while no sample is in
// flight; every sample carries its own copy of the settings down the pipe.
// Reset: rst_ni clears the registers to fold mode, -5..5 V range and
// symmetric gain, and drops any sample in flight.
module wave_fold_wrap (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Sample channel
  input  logic                                start,
  output logic                                busy,
  input  logic signed [wfw_pkg::SAMPLE_W-1:0] sample_in_i,
  input  logic        [wfw_pkg::GAIN_W-1:0]   gain_amount_i,
  input  logic signed [wfw_pkg::BIAS_W-1:0]   bias_amount_i,
  output logic                                done_o,
  output logic signed [wfw_pkg::OUT_W-1:0]    sample_out_o,
  // APB configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic        [wfw_pkg::PADDR_W-1:0]  paddr,
  input  logic        [wfw_pkg::PDATA_W-1:0]  pwdata,
  output logic        [wfw_pkg::PDATA_W-1:0]  prdata,
  output logic                                pready
);
  import wfw_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;
  logic in_fire;

  // The pipe never stalls, so the sample channel is always open
  assign busy    = 1'b0;
  assign in_fire = start & ~busy;
  assign pready  = 1'b1;

  // Register write on the APB access phase
  assign wr_en = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[3:2])
        REG_WRAP_MODE: cfg_d.wrap_mode       = pwdata[0];
        REG_UNIPOLAR:  cfg_d.unipolar_range  = pwdata[0];
        REG_ASYM_GAIN: cfg_d.asymmetric_gain = pwdata[0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back: one flag per register in bit 0
  always_comb begin
    unique case (paddr[3:2])
      REG_WRAP_MODE: prdata = PDATA_W'(cfg_q.wrap_mode);
      REG_UNIPOLAR:  prdata = PDATA_W'(cfg_q.unipolar_range);
      REG_ASYM_GAIN: prdata = PDATA_W'(cfg_q.asymmetric_gain);
      default:       prdata = '0;
    endcase
  end

  wfw_pipe u_pipe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_fire),
    .sample_in_i  (sample_in_i),
    .gain_amount_i(gain_amount_i),
    .bias_amount_i(bias_amount_i),
    .cfg_i        (cfg_q),
    .out_valid_o  (done_o),
    .sample_out_o (sample_out_o)
  );

endmodule

### rtl/wfw_pipe.sv
// Eight-stage datapath: gain, bias, rounding, then fold or wrap into range.
module wfw_pipe (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic signed [wfw_pkg::SAMPLE_W-1:0] sample_in_i,
  input  logic        [wfw_pkg::GAIN_W-1:0]   gain_amount_i,
  input  logic signed [wfw_pkg::BIAS_W-1:0]   bias_amount_i,
  input  wfw_pkg::cfg_t                       cfg_i,
  output logic                                out_valid_o,
  output logic signed [wfw_pkg::OUT_W-1:0]    sample_out_o
);
  import wfw_pkg::*;

  localparam logic signed [D_W-1:0]   CtrD     = D_W'(CTR_UNI);
  localparam logic signed [FAC_W-1:0] OneFac   = FAC_W'(ONE_GB);
  localparam logic signed [ACC_W-1:0] CtrTerm  = ACC_W'(CTR_UNI) <<< ACC_SHIFT;
  localparam logic signed [ACC_W-1:0] RoundC   = ACC_W'(1) <<< (ACC_SHIFT - 1);
  localparam logic signed [U_W-1:0]   MinBiU   = U_W'(MIN_BI);
  localparam logic signed [U_W-1:0]   SpanU    = U_W'(SPAN);
  localparam logic [X_W-1:0]          QOffX    = X_W'(Q_OFF);
  localparam logic [R_W-1:0]          SpanR    = R_W'(SPAN);
  localparam logic [R_W-1:0]          TwoSpanR = R_W'(TWO_SPAN);
  localparam logic [R_W-1:0]          EpsR     = R_W'(EPS_LSB);
  localparam logic signed [OUT_W-1:0] MinBiO   = OUT_W'(MIN_BI);
  localparam logic signed [OUT_W-1:0] MaxBiO   = OUT_W'(MIN_BI + SPAN);
  localparam logic signed [OUT_W-1:0] MaxUniO  = OUT_W'(SPAN);

  // Remainder by five of a short digit sum
  function automatic logic [2:0] mod5(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] r;
    r = s;
    if (r >= SUM_W'(40)) r = r - SUM_W'(40);
    if (r >= SUM_W'(20)) r = r - SUM_W'(20);
    if (r >= SUM_W'(10)) r = r - SUM_W'(10);
    if (r >= SUM_W'(5))  r = r - SUM_W'(5);
    return r[2:0];
  endfunction

  logic [STAGES-1:0] valid_q;
  cfg_t              cfg_q [STAGES-1];

  // Stage 1: center offset and asymmetric gain factor
  logic signed [D_W-1:0]   d_s1_d, d_s1_q;
  logic signed [FAC_W-1:0] fac_s1_d, fac_s1_q;
  logic [GAIN_W-1:0]       g_s1_q;
  logic signed [BIAS_W-1:0] b_s1_q, b_s2_q, b_s3_q;
  // Stage 2: gain times factor
  logic signed [D_W-1:0]   d_s2_q;
  logic signed [GF_W-1:0]  gf_s2_d, gf_s2_q;
  // Stage 3: offset times effective gain
  logic signed [PROD_W-1:0] prod_s3_d, prod_s3_q;
  // Stage 4: add center, bias and rounding constant
  logic signed [ACC_W-1:0] bias_x, bias_term, acc_s4_d, acc_s4_q;
  // Stage 5: rounded value relative to range bottom
  logic signed [Y_W-1:0]   y_s5;
  logic signed [U_W-1:0]   u_s5_d, u_s5_q;
  logic                    above_s5_d, oor_s5_d;
  logic                    above_q [3], oor_q [3];
  // Stage 6: digit sum of the upper part
  logic signed [Q_W-1:0]   q_s6;
  logic [X_W-1:0]          x_s6;
  logic [NIB_N*4-1:0]      xe_s6;
  logic [SUM_W-1:0]        sum_s6_d, sum_s6_q;
  logic [MOD_SH-1:0]       t_s6_q;
  logic [R_W-1:0]          uin_s6_q;
  // Stage 7: remainder by twice the span
  logic [R_W-1:0]          r_s7_d, r_s7_q;
  // Stage 8: fold or wrap
  logic [R_W-1:0]          r_fold, r_wrap, r_fin;
  logic signed [OUT_W-1:0] mn_o, out_d, out_q;
  logic                    hit_top;

  always_comb begin
    d_s1_d   = D_W'(sample_in_i) - (cfg_i.unipolar_range ? CtrD : '0);
    fac_s1_d = OneFac;
    if (cfg_i.asymmetric_gain) begin
      if (!d_s1_d[D_W-1] && (bias_amount_i[BIAS_W-1] || bias_amount_i == '0)) begin
        fac_s1_d = OneFac + FAC_W'(bias_amount_i);
      end else if (d_s1_d[D_W-1] && !bias_amount_i[BIAS_W-1]) begin
        fac_s1_d = OneFac - FAC_W'(bias_amount_i);
      end
    end
  end

  assign gf_s2_d   = GF_W'($signed({1'b0, g_s1_q})) * GF_W'(fac_s1_q);
  assign prod_s3_d = PROD_W'(d_s2_q) * PROD_W'(gf_s2_q);

  always_comb begin
    bias_x    = (ACC_W'(b_s3_q) <<< 2) + ACC_W'(b_s3_q);
    bias_term = bias_x <<< (FRAC_BITS + GB_FRAC);
    acc_s4_d  = ACC_W'(prod_s3_q) + bias_term + RoundC
              + (cfg_q[2].unipolar_range ? CtrTerm : '0);
  end

  always_comb begin
    y_s5       = acc_s4_q[ACC_W-1:ACC_SHIFT];
    u_s5_d     = U_W'(y_s5) - (cfg_q[3].unipolar_range ? '0 : MinBiU);
    above_s5_d = u_s5_d > SpanU;
    oor_s5_d   = u_s5_d[U_W-1] | above_s5_d;
  end

  always_comb begin
    q_s6     = u_s5_q[U_W-1:MOD_SH];
    x_s6     = X_W'(q_s6) + QOffX;
    xe_s6    = (NIB_N*4)'(x_s6);
    sum_s6_d = '0;
    for (int i = 0; i < NIB_N; i++) begin
      sum_s6_d = sum_s6_d + SUM_W'(xe_s6[4*i +: 4]);
    end
  end

  assign r_s7_d = oor_q[1] ? {mod5(sum_s6_q), t_s6_q} : uin_s6_q;

  always_comb begin
    r_fold  = (r_s7_q > SpanR) ? TwoSpanR - r_s7_q : r_s7_q;
    r_wrap  = (r_s7_q >= SpanR) ? r_s7_q - SpanR : r_s7_q;
    hit_top = (r_wrap <= EpsR) && above_q[2];
    r_fin   = !oor_q[2] ? r_s7_q : (cfg_q[6].wrap_mode ? r_wrap : r_fold);
    mn_o    = cfg_q[6].unipolar_range ? '0 : MinBiO;
    out_d   = mn_o + OUT_W'(r_fin);
    if (oor_q[2] && cfg_q[6].wrap_mode && hit_top) begin
      out_d = cfg_q[6].unipolar_range ? MaxUniO : MaxBiO;
    end
  end

  // Valid bits travel with the item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[STAGES-2:0], in_valid_i};
    end
  end

  // Payload: advance every cycle, no reset
  always_ff @(posedge clk_i) begin
    cfg_q[0] <= cfg_i;
    for (int i = 1; i < STAGES - 1; i++) begin
      cfg_q[i] <= cfg_q[i-1];
    end
    d_s1_q    <= d_s1_d;
    fac_s1_q  <= fac_s1_d;
    g_s1_q    <= gain_amount_i;
    b_s1_q    <= bias_amount_i;
    d_s2_q    <= d_s1_q;
    gf_s2_q   <= gf_s2_d;
    b_s2_q    <= b_s1_q;
    prod_s3_q <= prod_s3_d;
    b_s3_q    <= b_s2_q;
    acc_s4_q  <= acc_s4_d;
    u_s5_q    <= u_s5_d;
    above_q[0] <= above_s5_d;
    oor_q[0]   <= oor_s5_d;
    above_q[1] <= above_q[0];
    oor_q[1]   <= oor_q[0];
    above_q[2] <= above_q[1];
    oor_q[2]   <= oor_q[1];
    sum_s6_q  <= sum_s6_d;
    t_s6_q    <= u_s5_q[MOD_SH-1:0];
    uin_s6_q  <= u_s5_q[R_W-1:0];
    r_s7_q    <= r_s7_d;
    out_q     <= out_d;
  end

  assign out_valid_o  = valid_q[STAGES-1];
  assign sample_out_o = out_q;

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(in_valid_i, STAGES))
    else $error("result without a matching input transfer");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[STAGES-2] |-> (r_s7_q < TwoSpanR))
    else $error("remainder not below twice the span");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[STAGES-2] |=>
      (sample_out_o >= ($past(cfg_q[6].unipolar_range) ? OUT_W'(0) : MinBiO)) &&
      (sample_out_o <= ($past(cfg_q[6].unipolar_range) ? MaxUniO : MaxBiO)))
    else $error("result outside selected range");
`endif

endmodule

### bench/wave_fold_wrap_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the wave folder / wrapper: directed table, then random samples.
module wave_fold_wrap_tb;
  import wfw_pkg::*;

  // One row of stimulus: the settings it runs under, the sample transfer and,
  // where it can be read off directly, the folded voltage it must give.
  typedef struct {
    cfg_t                       cfg;
    logic signed [SAMPLE_W-1:0] sample;
    logic        [GAIN_W-1:0]   gain;
    logic signed [BIAS_W-1:0]   bias;
    bit                         known;
    logic signed [OUT_W-1:0]    volts;
  } fold_case_t;

  typedef struct {
    int                      idx;
    logic signed [OUT_W-1:0] volts;
  } volt_exp_t;

  // Settings in {wrap_mode, unipolar_range, asymmetric_gain} order
  localparam cfg_t FOLD_BI      = 3'b000;
  localparam cfg_t WRAP_BI      = 3'b100;
  localparam cfg_t FOLD_UNI     = 3'b010;
  localparam cfg_t WRAP_UNI     = 3'b110;
  localparam cfg_t ASYM_FOLD_BI = 3'b001;
  localparam cfg_t ALL_ON       = 3'b111;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start;
  logic                       busy;
  logic signed [SAMPLE_W-1:0] sample_in_i;
  logic        [GAIN_W-1:0]   gain_amount_i;
  logic signed [BIAS_W-1:0]   bias_amount_i;
  logic                       done_o;
  logic signed [OUT_W-1:0]    sample_out_o;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic        [PADDR_W-1:0]  paddr;
  logic        [PDATA_W-1:0]  pwdata;
  logic        [PDATA_W-1:0]  prdata;
  logic                       pready;

  cfg_t       shadow_cfg;      // what the register block should hold now
  fold_case_t case_rows[$];    // directed table
  volt_exp_t  pending_volts[$]; // folded voltages still owed by the pipe
  volt_exp_t  oldest_volt;
  int         items_sent;
  int         fail_count;

  wave_fold_wrap u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .sample_in_i   (sample_in_i),
    .gain_amount_i (gain_amount_i),
    .bias_amount_i (bias_amount_i),
    .done_o        (done_o),
    .sample_out_o  (sample_out_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Hard stop well past the slowest legal run.
  initial begin
    #200000;
    $display("Simulation FAILED");
    $finish;
  end

  // Gain about the center, bias times half the span, one round-half-up step,
  // then fold or wrap back into the selected range.
  function automatic logic signed [OUT_W-1:0] fold_wrap_voltage(
    cfg_t c, logic signed [SAMPLE_W-1:0] s, logic [GAIN_W-1:0] g,
    logic signed [BIAS_W-1:0] b);
    longint v, gl, bl, lo, hi, mid, fac, acc, y, r;
    v   = s;
    gl  = g;
    bl  = b;
    lo  = c.unipolar_range ? 0 : MIN_BI;
    hi  = lo + SPAN;
    mid = lo + 5 * ONE_V;
    fac = ONE_GB;
    // Asymmetric: negative bias weakens the upper half, positive the lower
    if (c.asymmetric_gain) begin
      if (v >= mid && bl <= 0) fac = fac + bl;
      else if (v < mid && bl >= 0) fac = fac - bl;
    end
    acc = (mid <<< ACC_SHIFT) + (v - mid) * (gl * fac)
        + bl * (5 * ONE_V) * (longint'(1) <<< GB_FRAC);
    y = (acc + (longint'(1) <<< (ACC_SHIFT - 1))) >>> ACC_SHIFT;
    if (y < lo || y > hi) begin
      if (!c.wrap_mode) begin
        // Triangle fold over a period of twice the span
        r = (y - lo) % TWO_SPAN;
        if (r < 0) r = r + TWO_SPAN;
        if (r > SPAN) r = TWO_SPAN - r;
        y = lo + r;
      end else begin
        // Wrap; landing on the lower edge from above gives the top edge
        r = (y - lo) % SPAN;
        if (r < 0) r = r + SPAN;
        if (r <= EPS_LSB && y > hi) y = hi;
        else y = lo + r;
      end
    end
    return y[OUT_W-1:0];
  endfunction

  task automatic note_fail(string msg);
    fail_count++;
    if (fail_count <= 10) $display("MISMATCH: %s", msg);
  endtask

  task automatic add_row(cfg_t c, int s, int g, int b, bit known, int v);
    fold_case_t fc;
    fc.cfg    = c;
    fc.sample = s[SAMPLE_W-1:0];
    fc.gain   = g[GAIN_W-1:0];
    fc.bias   = b[BIAS_W-1:0];
    fc.known  = known;
    fc.volts  = v[OUT_W-1:0];
    case_rows.push_back(fc);
  endtask

  // Present one sample and hold it until the transfer is taken, then log
  // the voltage it must produce.
  task automatic send_sample(fold_case_t fc);
    volt_exp_t ve;
    @(negedge clk_i);
    start         <= 1'b1;
    sample_in_i   <= fc.sample;
    gain_amount_i <= fc.gain;
    bias_amount_i <= fc.bias;
    do @(posedge clk_i); while (busy);
    ve.idx   = items_sent;
    ve.volts = fc.known ? fc.volts
                        : fold_wrap_voltage(shadow_cfg, fc.sample, fc.gain, fc.bias);
    pending_volts.push_back(ve);
    items_sent++;
  endtask

  task automatic hold_off(int n);
    @(negedge clk_i) start <= 1'b0;
    repeat (n - 1) @(posedge clk_i);
  endtask

  // Drop start and wait for every owed result to come out.
  task automatic drain_pipe();
    @(negedge clk_i) start <= 1'b0;
    while (pending_volts.size() != 0) @(posedge clk_i);
  endtask

  // Write one register with junk in the unused bits, then read bit 0 back.
  task automatic write_reg(logic [1:0] idx, logic val);
    logic [PDATA_W-1:0] junk;
    junk = $urandom();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {junk[PDATA_W-1:1], val};
    @(negedge clk_i) penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_WRAP_MODE: shadow_cfg.wrap_mode       = val;
      REG_UNIPOLAR:  shadow_cfg.unipolar_range  = val;
      REG_ASYM_GAIN: shadow_cfg.asymmetric_gain = val;
      default: ;
    endcase
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i) penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[0] !== val)
      note_fail($sformatf("reg %0d readback exp %0b got %0b", idx, val, prdata[0]));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_cfg(cfg_t c);
    drain_pipe();
    write_reg(REG_WRAP_MODE, c.wrap_mode);
    write_reg(REG_UNIPOLAR, c.unipolar_range);
    write_reg(REG_ASYM_GAIN, c.asymmetric_gain);
  endtask

  // Mostly in-spec gain and bias, some samples parked on range edges and
  // half-span multiples, the rest raw bits in every field.
  function automatic fold_case_t random_case();
    fold_case_t fc;
    int         kind;
    int         t;
    logic [31:0] raw;
    fc.cfg   = shadow_cfg;
    fc.known = 1'b0;
    fc.volts = '0;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      if ($urandom_range(0, 1) != 0) t = int'($urandom_range(0, 49152)) - 24576;
      else t = int'($urandom_range(0, 262143)) - 131072;
      fc.sample = t[SAMPLE_W-1:0];
      t = int'($urandom_range(4096, 40960));
      fc.gain = t[GAIN_W-1:0];
      t = int'($urandom_range(0, 8192)) - 4096;
      fc.bias = t[BIAS_W-1:0];
    end else if (kind < 8) begin
      t = int'($urandom_range(0, 8)) * 20480 - 61440 + int'($urandom_range(0, 2)) - 1;
      fc.sample = t[SAMPLE_W-1:0];
      fc.gain   = ONE_GB[GAIN_W-1:0];
      fc.bias   = '0;
    end else begin
      raw = $urandom();
      fc.sample = raw[SAMPLE_W-1:0];
      raw = $urandom();
      fc.gain = raw[GAIN_W-1:0];
      raw = $urandom();
      fc.bias = raw[BIAS_W-1:0];
    end
    return fc;
  endfunction

  // Results cannot be held off: take each one in its strobe cycle.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_volts.size() == 0) begin
        note_fail($sformatf("result %0d with no sample pending", sample_out_o));
      end else begin
        oldest_volt = pending_volts.pop_front();
        if (sample_out_o !== oldest_volt.volts)
          note_fail($sformatf("sample %0d: exp %0d got %0d", oldest_volt.idx,
                              oldest_volt.volts, sample_out_o));
      end
    end
  end

  initial begin
    fold_case_t fc;
    cfg_t       blk_cfg;
    int         idle_pct;
    int         blk_num;
    logic [31:0] raw;

    rst_ni        = 1'b0;
    start         = 1'b0;
    sample_in_i   = '0;
    gain_amount_i = '0;
    bias_amount_i = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    shadow_cfg    = FOLD_BI;
    items_sent    = 0;
    fail_count    = 0;

    // Fold, bipolar, symmetric (reset settings)
    add_row(FOLD_BI, 0, 4096, 0, 1, 0);
    add_row(FOLD_BI, 4096, 4096, 0, 1, 4096);
    add_row(FOLD_BI, 20480, 4096, 0, 1, 20480);        // top edge passes
    add_row(FOLD_BI, -20480, 4096, 0, 1, -20480);      // bottom edge passes
    add_row(FOLD_BI, 24576, 4096, 0, 1, 16384);        // fold down from above
    add_row(FOLD_BI, -24576, 4096, 0, 1, -16384);      // fold up from below
    add_row(FOLD_BI, 0, 4096, 4096, 1, 20480);         // full positive bias
    add_row(FOLD_BI, 0, 4096, -4096, 1, -20480);       // full negative bias
    add_row(FOLD_BI, 131071, 65535, 8191, 0, 0);       // field maxima
    add_row(FOLD_BI, -131072, 0, -8192, 0, 0);         // field minima
    add_row(FOLD_BI, 12345, 40960, -1234, 0, 0);
    // Wrap, bipolar
    add_row(WRAP_BI, 61440, 4096, 0, 1, 20480);        // lower edge from above: top
    add_row(WRAP_BI, -61440, 4096, 0, 1, -20480);      // lower edge from below stays
    add_row(WRAP_BI, 24576, 4096, 0, 1, -16384);
    add_row(WRAP_BI, -131072, 65535, -8192, 0, 0);
    // Unipolar fold and wrap
    add_row(FOLD_UNI, 0, 4096, 0, 1, 0);
    add_row(FOLD_UNI, 40960, 4096, 0, 1, 40960);
    add_row(FOLD_UNI, -4096, 4096, 0, 1, 4096);
    add_row(WRAP_UNI, 81920, 4096, 0, 1, 40960);
    add_row(WRAP_UNI, -4096, 4096, 0, 1, 36864);
    // Asymmetric gain on each side of the center and right on it
    add_row(ASYM_FOLD_BI, 8192, 8192, -2048, 0, 0);
    add_row(ASYM_FOLD_BI, -8192, 8192, 2048, 0, 0);
    add_row(ASYM_FOLD_BI, 0, 8192, -2048, 0, 0);
    add_row(ASYM_FOLD_BI, 8192, 8192, 2048, 0, 0);
    add_row(ALL_ON, 100000, 40960, 4096, 0, 0);
    add_row(ALL_ON, -100000, 65535, -8192, 0, 0);

    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Walk the table back to back; rewrite settings only when a row needs it
    foreach (case_rows[i]) begin
      if (case_rows[i].cfg != shadow_cfg) apply_cfg(case_rows[i].cfg);
      send_sample(case_rows[i]);
    end

    // Random part: light sender gaps, then heavy, then none
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 34 : (ph == 1) ? 85 : 0;
      for (int blk = 0; blk < 4; blk++) begin
        blk_num = ph * 4 + blk;
        raw     = $urandom();
        blk_cfg = (blk_num == 0) ? FOLD_BI : (blk_num == 1) ? ALL_ON : cfg_t'(raw[2:0]);
        apply_cfg(blk_cfg);
        for (int n = 0; n < 38; n++) begin
          if (int'($urandom_range(0, 99)) < idle_pct) hold_off($urandom_range(1, 4));
          fc = random_case();
          send_sample(fc);
          // Hold the sender once until the pipe is empty
          if (ph == 1 && blk == 2 && n == 18) drain_pipe();
        end
      end
    end

    drain_pipe();
    repeat (STAGES + 4) @(posedge clk_i);
    if (fail_count == 0 && pending_volts.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
